// ===== hw/rtl/dvp_pkg.sv =====
`default_nettype none
package dvp_pkg;

  localparam int DIR_W  = 32;
  localparam int COEF_W = 32;
  localparam int CFG_W  = 64;
  localparam int NREG   = 8;
  localparam int IDX_W  = 3;
  localparam int PIX_W  = 16;
  localparam int SIZE_W = 15;
  localparam int VAL_W  = 64;
  localparam int ACC_W  = 66;
  localparam int QB     = 15;
  localparam int NUM_W  = VAL_W + SIZE_W + 1;

  localparam int XF_LAT  = 3;
  localparam int CTR_LAT = 6;
  localparam int DIV_LAT = 3 + QB;
  localparam int LATENCY = XF_LAT + DIV_LAT + 1;

  localparam int DEF_VIEW_WIDTH  = 1024;
  localparam int DEF_VIEW_HEIGHT = 768;

  localparam logic signed [ACC_W-1:0] W_MIN    = 66'sd87960931;
  localparam logic        [PIX_W-1:0] PIX_MAX  = 16'd32767;
  localparam logic        [27:0]      FIVE_P12 = 28'd244140625;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_ROW_X_01 = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROW_X_23 = 3'd1;
  localparam logic [IDX_W-1:0] REG_ROW_Y_01 = 3'd2;
  localparam logic [IDX_W-1:0] REG_ROW_Y_23 = 3'd3;
  localparam logic [IDX_W-1:0] REG_ROW_Z_01 = 3'd4;
  localparam logic [IDX_W-1:0] REG_ROW_Z_23 = 3'd5;
  localparam logic [IDX_W-1:0] REG_ROW_W_01 = 3'd6;
  localparam logic [IDX_W-1:0] REG_ROW_W_23 = 3'd7;

  localparam logic [CFG_W-1:0] ONE_LO = 64'h0000_0000_0001_0000;
  localparam logic [CFG_W-1:0] ONE_HI = 64'h0001_0000_0000_0000;

  typedef logic [NREG-1:0][CFG_W-1:0] mat_t;

  typedef struct packed {
    logic             vis;
    logic [VAL_W-1:0] ax;
    logic [VAL_W-1:0] ay;
    logic [VAL_W-1:0] w;
    logic [VAL_W-1:0] num_x;
    logic [VAL_W-1:0] num_y;
  } proj_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dvp_xform.sv =====
`default_nettype none
module dvp_xform import dvp_pkg::*; (
  input  wire logic                    clk,
  input  wire logic signed [DIR_W-1:0] dir_x,
  input  wire logic signed [DIR_W-1:0] dir_y,
  input  wire logic signed [DIR_W-1:0] dir_z,
  input  wire mat_t                    mat,
  output proj_t                        proj
);

  logic signed [DIR_W:0]         v [3];
  logic signed [COEF_W-1:0]      coef [4][4];
  logic signed [2*DIR_W:0]       prod_r [4][3];
  logic signed [COEF_W-1:0]      tr_r [4];
  logic signed [ACC_W-1:0]       sum_r [4];
  logic signed [ACC_W-1:0]       xn, yn, zn, wn, nx, ny;
  logic                          usable, neg;
  proj_t                         proj_nxt, proj_r;

  // Negate; the most negative input becomes +4.0
  assign v[0] = (DIR_W+1)'(0) - {dir_x[DIR_W-1], dir_x};
  assign v[1] = (DIR_W+1)'(0) - {dir_y[DIR_W-1], dir_y};
  assign v[2] = (DIR_W+1)'(0) - {dir_z[DIR_W-1], dir_z};

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      coef[r][0] = mat[2*r][COEF_W-1:0];
      coef[r][1] = mat[2*r][CFG_W-1:COEF_W];
      coef[r][2] = mat[2*r+1][COEF_W-1:0];
      coef[r][3] = mat[2*r+1][CFG_W-1:COEF_W];
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_r[r][c] <= coef[r][c] * v[c];
      end
      tr_r[r] <= coef[r][3];
    end
  end

  // Floor each product to Q.43 and add the scaled translation
  always_ff @(posedge clk) begin
    for (int r = 0; r < 4; r++) begin
      sum_r[r] <= (ACC_W'(prod_r[r][0]) >>> 2) + (ACC_W'(prod_r[r][1]) >>> 2)
                + (ACC_W'(prod_r[r][2]) >>> 2) + (ACC_W'(tr_r[r]) <<< 27);
    end
  end

  always_comb begin
    usable = (sum_r[3] >= W_MIN) || (sum_r[3] <= -W_MIN);
    neg    = sum_r[3][ACC_W-1];
    xn     = neg ? -sum_r[0] : sum_r[0];
    yn     = neg ? -sum_r[1] : sum_r[1];
    zn     = neg ? -sum_r[2] : sum_r[2];
    wn     = neg ? -sum_r[3] : sum_r[3];
    nx     = wn + xn;
    ny     = wn - yn;
    proj_nxt.vis   = usable && !nx[ACC_W-1] && !ny[ACC_W-1] && !zn[ACC_W-1];
    proj_nxt.ax    = VAL_W'(xn[ACC_W-1] ? -xn : xn);
    proj_nxt.ay    = VAL_W'(yn[ACC_W-1] ? -yn : yn);
    proj_nxt.w     = VAL_W'(wn);
    proj_nxt.num_x = VAL_W'(nx);
    proj_nxt.num_y = VAL_W'(ny);
  end

  always_ff @(posedge clk) begin
    proj_r <= proj_nxt;
  end

  assign proj = proj_r;

endmodule
`default_nettype wire

// ===== hw/rtl/dvp_mul64.sv =====
`default_nettype none
module dvp_mul64 import dvp_pkg::*; (
  input  wire logic               clk,
  input  wire logic [VAL_W-1:0]   a,
  input  wire logic [VAL_W-1:0]   b,
  output logic      [2*VAL_W-1:0] p
);

  localparam int H = VAL_W / 2;

  logic [VAL_W-1:0]   pp_r [4];
  logic [2*VAL_W-1:0] p_r;

  always_ff @(posedge clk) begin
    pp_r[0] <= VAL_W'(a[H-1:0])     * VAL_W'(b[H-1:0]);
    pp_r[1] <= VAL_W'(a[VAL_W-1:H]) * VAL_W'(b[H-1:0]);
    pp_r[2] <= VAL_W'(a[H-1:0])     * VAL_W'(b[VAL_W-1:H]);
    pp_r[3] <= VAL_W'(a[VAL_W-1:H]) * VAL_W'(b[VAL_W-1:H]);
  end

  always_ff @(posedge clk) begin
    p_r <= (2*VAL_W)'(pp_r[0]) + ((2*VAL_W)'(pp_r[1]) << H)
         + ((2*VAL_W)'(pp_r[2]) << H) + ((2*VAL_W)'(pp_r[3]) << VAL_W);
  end

  assign p = p_r;

endmodule
`default_nettype wire

// ===== hw/rtl/dvp_centre.sv =====
`default_nettype none
module dvp_centre import dvp_pkg::*; (
  input  wire logic             clk,
  input  wire logic [VAL_W-1:0] ax,
  input  wire logic [VAL_W-1:0] ay,
  input  wire logic [VAL_W-1:0] w,
  output logic                  centre
);

  localparam int PW = 2 * VAL_W;
  localparam int CK = 29;

  logic [PW-1:0]      sqx, sqy, sqw;
  logic [PW-1:0]      s_r, w2_r, w2a_r, w2b_r, sc_r;
  logic [CK+27:0]     pc_r [3];
  logic               big_r, bigb_r, centre_r;

  dvp_mul64 u_mx (.clk(clk), .a(ax), .b(ax), .p(sqx));
  dvp_mul64 u_my (.clk(clk), .a(ay), .b(ay), .p(sqy));
  dvp_mul64 u_mw (.clk(clk), .a(w),  .b(w),  .p(sqw));

  always_ff @(posedge clk) begin
    s_r  <= sqx + sqy;
    w2_r <= sqw;
  end

  // Any sum at or above 2^87 already exceeds W^2 after the 1e12 scale
  always_ff @(posedge clk) begin
    big_r <= |s_r[PW-1:3*CK];
    for (int i = 0; i < 3; i++) begin
      pc_r[i] <= (CK+28)'(s_r[CK*i +: CK]) * (CK+28)'(FIVE_P12);
    end
    w2a_r <= w2_r;
  end

  always_ff @(posedge clk) begin
    sc_r   <= (PW'(pc_r[0]) + (PW'(pc_r[1]) << CK) + (PW'(pc_r[2]) << (2*CK))) << 12;
    bigb_r <= big_r;
    w2b_r  <= w2a_r;
  end

  always_ff @(posedge clk) begin
    centre_r <= !bigb_r && (sc_r < w2b_r);
  end

  assign centre = centre_r;

endmodule
`default_nettype wire

// ===== hw/rtl/dvp_div.sv =====
`default_nettype none
module dvp_div import dvp_pkg::*; #(
  parameter int SIZE = DEF_VIEW_WIDTH
) (
  input  wire logic             clk,
  input  wire logic [VAL_W-1:0] num,
  input  wire logic [VAL_W-1:0] w,
  output logic      [QB-1:0]    q,
  output logic                  sat
);

  localparam int H  = VAL_W / 2;
  localparam int PW = H + SIZE_W;
  localparam logic [SIZE_W-1:0] SIZE_C = SIZE_W'(SIZE);

  logic [PW-1:0]    plo_r, phi_r;
  logic [VAL_W-1:0] wa_r;
  logic [NUM_W-1:0] n_r;
  logic [VAL_W:0]   d_r;
  logic [NUM_W-1:0] rem_r [QB+1];
  logic [VAL_W:0]   dd_r  [QB+1];
  logic [QB-1:0]    q_r   [QB+1];
  logic             sat_r [QB+1];

  always_ff @(posedge clk) begin
    plo_r <= PW'(num[H-1:0])     * PW'(SIZE_C);
    phi_r <= PW'(num[VAL_W-1:H]) * PW'(SIZE_C);
    wa_r  <= w;
  end

  always_ff @(posedge clk) begin
    n_r <= NUM_W'(plo_r) + (NUM_W'(phi_r) << H);
    d_r <= {wa_r, 1'b0};
  end

  // A quotient that needs more than QB bits saturates
  always_ff @(posedge clk) begin
    rem_r[0] <= n_r;
    dd_r[0]  <= d_r;
    q_r[0]   <= '0;
    sat_r[0] <= n_r >= (NUM_W'(d_r) << QB);
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [NUM_W-1:0] sh;
    logic             ge;
    assign sh = NUM_W'(dd_r[k-1]) << (QB - k);
    assign ge = rem_r[k-1] >= sh;
    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? rem_r[k-1] - sh : rem_r[k-1];
      dd_r[k]  <= dd_r[k-1];
      q_r[k]   <= {q_r[k-1][QB-2:0], ge};
      sat_r[k] <= sat_r[k-1];
    end
  end

  assign q   = q_r[QB];
  assign sat = sat_r[QB];

endmodule
`default_nettype wire

// ===== hw/rtl/direction_to_viewport_projector.sv =====
`default_nettype none
// Projects a direction vector through a 4x4 view-projection matrix onto a viewport.
// Input: pulse start with in_dir_x/y/z (signed Q2.29); an item transfers when start
// is high and busy is low. busy is high during reset and in the cycle after it.
// Output: out_valid strobes for one cycle with out_visible, out_pixel_x/y and
// out_clamped. The receiver cannot hold results off; every item yields one result.
// One item per cycle while busy is low. The pixel divider resolves one
// quotient bit per stage (15 stages) after the matrix product (3 stages)
// and the scale multiply.
// Config: cfg_valid/cfg_ready with cfg_index and 64-bit cfg_data write one matrix
// register (two Q16.16 words, low word first). cfg_ready is always high. Write
// registers only while no item is in flight.
// Reset: the matrix returns to identity and the pipeline valid bits clear;
// items in flight are dropped.
module direction_to_viewport_projector import dvp_pkg::*; #(
  parameter int VIEW_WIDTH  = DEF_VIEW_WIDTH,
  parameter int VIEW_HEIGHT = DEF_VIEW_HEIGHT
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic signed [DIR_W-1:0] in_dir_x,
  input  wire logic signed [DIR_W-1:0] in_dir_y,
  input  wire logic signed [DIR_W-1:0] in_dir_z,
  output logic                         out_valid,
  output logic                         out_visible,
  output logic signed [PIX_W-1:0]      out_pixel_x,
  output logic signed [PIX_W-1:0]      out_pixel_y,
  output logic                         out_clamped,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_data
);

  localparam int VLEN = LATENCY - 1;
  localparam int CDLY = DIV_LAT - CTR_LAT;
  localparam logic [PIX_W-1:0] HALF_W = PIX_W'(VIEW_WIDTH / 2);
  localparam logic [PIX_W-1:0] HALF_H = PIX_W'(VIEW_HEIGHT / 2);

  mat_t            mat_r;
  logic            busy_r;
  logic [VLEN-1:0] vld_r;
  proj_t           proj;
  logic            ctr;
  logic [CDLY-1:0] ctr_d_r;
  logic [DIV_LAT-1:0] vis_d_r;
  logic [QB-1:0]   qx, qy;
  logic            satx, saty;
  logic            out_valid_r, out_visible_r, out_clamped_r;
  logic [PIX_W-1:0] out_px_r, out_py_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r[REG_ROW_X_01] <= ONE_LO;
      mat_r[REG_ROW_X_23] <= '0;
      mat_r[REG_ROW_Y_01] <= ONE_HI;
      mat_r[REG_ROW_Y_23] <= '0;
      mat_r[REG_ROW_Z_01] <= '0;
      mat_r[REG_ROW_Z_23] <= ONE_LO;
      mat_r[REG_ROW_W_01] <= '0;
      mat_r[REG_ROW_W_23] <= ONE_HI;
    end else if (cfg_valid && cfg_ready) begin
      mat_r[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      vld_r       <= {vld_r[VLEN-2:0], start && !busy_r};
      out_valid_r <= vld_r[VLEN-1];
    end
  end

  assign busy = busy_r;

  dvp_xform u_xform (
    .clk(clk), .dir_x(in_dir_x), .dir_y(in_dir_y), .dir_z(in_dir_z),
    .mat(mat_r), .proj(proj)
  );

  dvp_centre u_centre (
    .clk(clk), .ax(proj.ax), .ay(proj.ay), .w(proj.w), .centre(ctr)
  );

  dvp_div #(.SIZE(VIEW_WIDTH)) u_div_x (
    .clk(clk), .num(proj.num_x), .w(proj.w), .q(qx), .sat(satx)
  );

  dvp_div #(.SIZE(VIEW_HEIGHT)) u_div_y (
    .clk(clk), .num(proj.num_y), .w(proj.w), .q(qy), .sat(saty)
  );

  // Align the centre and visibility flags with the divider outputs
  always_ff @(posedge clk) begin
    ctr_d_r <= {ctr_d_r[CDLY-2:0], ctr};
    vis_d_r <= {vis_d_r[DIV_LAT-2:0], proj.vis};
  end

  always_ff @(posedge clk) begin
    if (!vis_d_r[DIV_LAT-1]) begin
      out_visible_r <= 1'b0;
      out_px_r      <= '0;
      out_py_r      <= '0;
      out_clamped_r <= 1'b0;
    end else if (ctr_d_r[CDLY-1]) begin
      out_visible_r <= 1'b1;
      out_px_r      <= HALF_W;
      out_py_r      <= HALF_H;
      out_clamped_r <= 1'b0;
    end else begin
      out_visible_r <= 1'b1;
      out_px_r      <= satx ? PIX_MAX : PIX_W'(qx);
      out_py_r      <= saty ? PIX_MAX : PIX_W'(qy);
      out_clamped_r <= satx || saty;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;
  assign out_pixel_x = out_px_r;
  assign out_pixel_y = out_py_r;
  assign out_clamped = out_clamped_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LATENCY out_valid)
    else $error("accepted item did not produce a result on time");

  a_clamp_vis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clamped |-> out_visible)
    else $error("clamped result not marked visible");

  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_visible |-> out_pixel_x == '0 && out_pixel_y == '0 && !out_clamped)
    else $error("hidden result carries nonzero fields");

  a_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_visible |-> !out_pixel_x[PIX_W-1] && !out_pixel_y[PIX_W-1])
    else $error("visible result has negative pixel");

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none
module tb;
  import dvp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VIEW_W = DEF_VIEW_WIDTH;
  localparam int VIEW_H = DEF_VIEW_HEIGHT;
  localparam int CYCLE_LIMIT = 400000;
  localparam longint W_FLOOR = 64'sd87960931;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;
  localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;

  typedef struct {
    logic                    vis;
    logic signed [PIX_W-1:0] px;
    logic signed [PIX_W-1:0] py;
    logic                    clamped;
  } pixel_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [DIR_W-1:0] in_dir_x = '0;
  logic signed [DIR_W-1:0] in_dir_y = '0;
  logic signed [DIR_W-1:0] in_dir_z = '0;
  logic out_valid, out_visible, out_clamped;
  logic signed [PIX_W-1:0] out_pixel_x, out_pixel_y;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  logic [CFG_W-1:0] matrix [NREG];
  pixel_result_t pending_pixels [$];
  int fail_count = 0;
  int sender_idle = 0;
  longint cycle_count = 0;

  direction_to_viewport_projector dut (
    .clk, .rst_n, .start, .busy, .in_dir_x, .in_dir_y, .in_dir_z,
    .out_valid, .out_visible, .out_pixel_x, .out_pixel_y, .out_clamped,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic longint row_dot(int r, longint vx, longint vy, longint vz);
    longint c0, c1, c2, c3;
    c0 = longint'($signed(matrix[2*r][31:0]));
    c1 = longint'($signed(matrix[2*r][63:32]));
    c2 = longint'($signed(matrix[2*r+1][31:0]));
    c3 = longint'($signed(matrix[2*r+1][63:32]));
    return ((c0 * vx) >>> 2) + ((c1 * vy) >>> 2) + ((c2 * vz) >>> 2) + c3 * 134217728;
  endfunction

  function automatic logic [15:0] scale_pixel(logic signed [127:0] num,
                                              logic signed [127:0] w, int size,
                                              inout logic sat);
    logic signed [127:0] q;
    q = (num * size) / (2 * w);
    if (q > 32767) begin
      sat = 1'b1;
      return PIX_MAX;
    end
    return q[15:0];
  endfunction

  function automatic pixel_result_t project_dir(logic signed [31:0] dx,
                                                logic signed [31:0] dy,
                                                logic signed [31:0] dz);
    pixel_result_t res;
    longint vx, vy, vz, hx, hy, hz, hw, ax, ay;
    logic [191:0] lhs, rhs;
    logic sat;
    vx = -longint'(dx);
    vy = -longint'(dy);
    vz = -longint'(dz);
    hx = row_dot(0, vx, vy, vz);
    hy = row_dot(1, vx, vy, vz);
    hz = row_dot(2, vx, vy, vz);
    hw = row_dot(3, vx, vy, vz);
    res = '{1'b0, '0, '0, 1'b0};
    if (hw > -W_FLOOR && hw < W_FLOOR) return res;
    if (hw < 0) begin
      hx = -hx; hy = -hy; hz = -hz; hw = -hw;
    end
    if (!(hx >= -hw && hy <= hw && hz >= 0)) return res;
    res.vis = 1'b1;
    ax = (hx < 0) ? -hx : hx;
    ay = (hy < 0) ? -hy : hy;
    if (ax <= hw / 1000000 && ay <= hw / 1000000) begin
      lhs = (192'(ax) * 192'(ax) + 192'(ay) * 192'(ay)) * 192'd1000000000000;
      rhs = 192'(hw) * 192'(hw);
      if (lhs < rhs) begin
        res.px = 16'(VIEW_W / 2);
        res.py = 16'(VIEW_H / 2);
        return res;
      end
    end
    sat = 1'b0;
    res.px = scale_pixel(128'(hw) + 128'(hx), 128'(hw), VIEW_W, sat);
    res.py = scale_pixel(128'(hw) - 128'(hy), 128'(hw), VIEW_H, sat);
    res.clamped = sat;
    return res;
  endfunction

  always @(posedge clk) begin
    pixel_result_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_pixels.size() == 0) begin
        $error("result with nothing pending");
        fail_count++;
      end else begin
        exp_r = pending_pixels.pop_front();
        if (out_visible !== exp_r.vis) begin
          $error("visible expected %0d actual %0d", exp_r.vis, out_visible);
          fail_count++;
        end
        if (out_pixel_x !== exp_r.px) begin
          $error("pixel_x expected %0d actual %0d", exp_r.px, out_pixel_x);
          fail_count++;
        end
        if (out_pixel_y !== exp_r.py) begin
          $error("pixel_y expected %0d actual %0d", exp_r.py, out_pixel_y);
          fail_count++;
        end
        if (out_clamped !== exp_r.clamped) begin
          $error("clamped expected %0d actual %0d", exp_r.clamped, out_clamped);
          fail_count++;
        end
      end
    end
  end

  task automatic send_dir(logic signed [31:0] dx, logic signed [31:0] dy,
                          logic signed [31:0] dz);
    while ($urandom_range(99) < sender_idle) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    in_dir_x = dx;
    in_dir_y = dy;
    in_dir_z = dz;
    do @(posedge clk); while (busy);
    pending_pixels.push_back(project_dir(dx, dy, dz));
  endtask

  task automatic drain;
    @(negedge clk);
    start = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    matrix[idx] = data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // m holds {hi, lo} words in register order
  task automatic load_matrix(logic [CFG_W-1:0] m [NREG]);
    drain();
    write_reg(REG_ROW_X_01, m[0]);
    write_reg(REG_ROW_X_23, m[1]);
    write_reg(REG_ROW_Y_01, m[2]);
    write_reg(REG_ROW_Y_23, m[3]);
    write_reg(REG_ROW_Z_01, m[4]);
    write_reg(REG_ROW_Z_23, m[5]);
    write_reg(REG_ROW_W_01, m[6]);
    write_reg(REG_ROW_W_23, m[7]);
  endtask

  // w follows dz, so small dz drives w toward zero and its sign flips with dz
  task automatic load_perspective(bit jitter);
    logic [CFG_W-1:0] m [NREG];
    logic [31:0] fx, fy, tz;
    fx = jitter ? 32'($urandom_range(32'h0003_0000, 32'h0000_4000)) : Q_ONE;
    fy = jitter ? 32'($urandom_range(32'h0003_0000, 32'h0000_4000)) : Q_ONE;
    tz = jitter ? 32'($urandom_range(32'h0000_8000)) : 32'h0;
    m[0] = {32'h0, fx};
    m[1] = {32'h0, 32'h0};
    m[2] = {fy, 32'h0};
    m[3] = {32'h0, 32'h0};
    m[4] = {32'h0, 32'h0};
    m[5] = {tz, Q_NEG_ONE};
    m[6] = {32'h0, 32'h0};
    m[7] = {32'h0, Q_NEG_ONE};
    load_matrix(m);
  endtask

  task automatic load_random_matrix;
    logic [CFG_W-1:0] m [NREG];
    for (int i = 0; i < NREG; i++) m[i] = {$urandom, $urandom};
    load_matrix(m);
  endtask

  task automatic load_uniform(logic [31:0] word);
    logic [CFG_W-1:0] m [NREG];
    for (int i = 0; i < NREG; i++) m[i] = {word, word};
    load_matrix(m);
  endtask

  task automatic send_shaped;
    longint mag, dz, dx, dy;
    int pick;
    pick = $urandom_range(99);
    if (pick < 25) begin
      send_dir($urandom, $urandom, $urandom);
    end else begin
      case ($urandom_range(3))
        0: mag = $urandom_range(32'h2000_0000);
        1: mag = $urandom_range(32'h0010_0000);
        2: mag = $urandom_range(12000);
        default: mag = $urandom_range(32'h7FFF_FFFF);
      endcase
      dz = $urandom_range(1) ? mag : -mag;
      dx = longint'($urandom_range(32'(2 * mag))) - mag;
      dy = longint'($urandom_range(32'(2 * mag))) - mag;
      if ($urandom_range(7) == 0) dx = dx * 3;
      send_dir(32'(dx), 32'(dy), 32'(dz));
    end
  endtask

  task automatic test_reset_identity;
    sender_idle = 0;
    send_dir(32'sh0, 32'sh0, 32'sh0);
    send_dir(32'sh2000_0000, 32'shE000_0000, 32'sh0);
    send_dir(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_dir(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_dir(32'shC000_0000, 32'sh4000_0000, 32'sh1234_5678);
    send_dir(32'sh0000_0001, 32'shFFFF_FFFF, 32'sh0);
  endtask

  task automatic test_directed_corners;
    load_perspective(1'b0);
    send_dir(32'sh0, 32'sh0, 32'sh2000_0000);
    send_dir(32'sh0, 32'sh0, 32'shE000_0000);
    send_dir(32'sh1000_0000, 32'sh0, 32'sh0000_1388);
    send_dir(32'sh1000_0000, 32'sh0, 32'shFFFF_EC78);
    send_dir(32'sh0, 32'sh0, 32'sh0000_157D);
    send_dir(32'sh0, 32'sh0, 32'sh0000_157C);
    send_dir(32'sh2000_0000, 32'shE000_0000, 32'sh0000_2000);
    send_dir(32'shE000_0000, 32'sh2000_0000, 32'sh0001_0000);
    send_dir(32'sh2000_0000, 32'sh2000_0000, 32'sh2000_0000);
    send_dir(32'shE000_0000, 32'shE000_0000, 32'sh2000_0000);
    send_dir(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_dir(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_dir(32'sh0000_0100, 32'sh0000_0100, 32'sh4000_0000);
    send_dir(32'sh1FFF_FFFF, 32'sh0, 32'sh2000_0000);
  endtask

  task automatic test_random_phase(int idle_pct, int count, int setting);
    case (setting)
      0: load_perspective(1'b1);
      1: load_random_matrix();
      2: load_uniform(32'h7FFF_FFFF);
      3: load_uniform(32'h8000_0000);
      default: load_uniform(32'hFFFF_FFFF);
    endcase
    sender_idle = idle_pct;
    for (int n = 0; n < count; n++) begin
      send_shaped();
      // hold off once mid-phase until the pipeline is empty
      if (n == count / 2 && setting == 0) begin
        @(negedge clk);
        start = 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
      end
    end
  endtask

  initial begin
    matrix[0] = ONE_LO; matrix[1] = '0; matrix[2] = ONE_HI; matrix[3] = '0;
    matrix[4] = '0; matrix[5] = ONE_LO; matrix[6] = '0; matrix[7] = ONE_HI;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_identity();
    test_directed_corners();
    test_random_phase(0, 250, 0);
    test_random_phase(82, 200, 0);
    test_random_phase(9, 200, 0);
    test_random_phase(9, 120, 1);
    test_random_phase(0, 60, 2);
    test_random_phase(82, 60, 3);
    test_random_phase(0, 60, 4);
    drain();
    if (fail_count == 0 && pending_pixels.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
